// ===== rtl/core/acia_pkg.sv =====
// Shared types, codes and helpers for the ACIA serial interface unit.
`timescale 1ns / 1ps

package acia_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [2:0] {
    ACT_READ     = 3'd0,
    ACT_WRITE    = 3'd1,
    ACT_RX_BIT   = 3'd2,
    ACT_RX_TICK  = 3'd3,
    ACT_TX_HALF  = 3'd4,
    ACT_TX_SHIFT = 3'd5,
    ACT_DCD      = 3'd6,
    ACT_CTS      = 3'd7
  } action_t;

  // Receiver framing phase
  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_DATA   = 2'd1,
    PH_PARITY = 2'd2,
    PH_STOP   = 2'd3
  } rx_phase_t;

  // Status register bit positions
  localparam int ST_RDRF = 0;
  localparam int ST_TDRE = 1;
  localparam int ST_DCD  = 2;
  localparam int ST_CTS  = 3;
  localparam int ST_FE   = 4;
  localparam int ST_OVRN = 5;
  localparam int ST_PE   = 6;
  localparam int ST_IRQ  = 7;

  // Control register fields
  localparam int CR_WS_ODD    = 2;
  localparam int CR_WS_PARITY = 3;
  localparam int CR_WS_8BIT   = 4;
  localparam int CR_RIE       = 7;
  localparam logic [7:0] CR_TXC_MASK    = 8'h60;
  localparam logic [7:0] CR_TXC_IRQ     = 8'h20;
  localparam logic [7:0] CR_TXC_RTS_OFF = 8'h40;

  // Divider select codes in control bits [1:0]
  localparam logic [1:0] DIV_SEL_1      = 2'd0;
  localparam logic [1:0] DIV_SEL_16     = 2'd1;
  localparam logic [1:0] DIV_SEL_MRESET = 2'd3;

  // Divider values
  localparam logic [6:0] DIV_1  = 7'd1;
  localparam logic [6:0] DIV_16 = 7'd16;
  localparam logic [6:0] DIV_64 = 7'd64;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_STATE    = 2'd1;
  localparam logic [1:0] ERR_TX_CLOCK = 2'd2;

  // Index of the last shift step of a transmit frame
  localparam logic [3:0] TX_LAST_7 = 4'd8;
  localparam logic [3:0] TX_LAST_8 = 4'd9;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  // One result word, lowest field in the lowest bits
  typedef struct packed {
    logic [6:0] pad;
    logic       rx_frame_ready;
    logic       rx_awaiting_start;
    logic [1:0] error_code;
    logic [6:0] clock_divider;
    logic       rx_clock_fire;
    logic       tx_bit_due;
    logic       tx_bit_valid;
    logic       tx_bit;
    logic       rts;
    logic       irq;
    logic [7:0] status_view;
    logic [7:0] read_data;
  } result_t;

  typedef struct packed {
    logic [7:0] st;
    logic [7:0] seen;
  } refresh_t;

  // Recompute the IRQ bit and the software view of status
  function automatic refresh_t acia_refresh(input logic [7:0] ctrl, input logic [7:0] st,
                                            input logic dcd, input logic cts);
    refresh_t r;
    logic send;
    logic recv;
    send = ((ctrl & CR_TXC_MASK) == CR_TXC_IRQ) && st[ST_TDRE] && !st[ST_CTS];
    recv = ctrl[CR_RIE] && (st[ST_RDRF] || st[ST_DCD] || st[ST_OVRN]);
    r.st = st;
    r.st[ST_IRQ] = send || recv;
    r.seen = r.st;
    if (r.st[ST_CTS]) r.seen[ST_TDRE] = 1'b0;
    if (dcd && !cts) r.seen[ST_DCD] = 1'b1;
    return r;
  endfunction

endpackage

// ===== rtl/core/acia_serial_interface_unit.sv =====
// Top level of the ACIA serial interface unit: register file, receiver, transmitter.
`timescale 1ns / 1ps

// ACIA serial interface unit. Each input word is one event (bus read or write,
// received bit, receive clock tick, transmit half tick, transmit shift step, DCD
// or CTS change) and yields exactly one result word in the cycle after it is
// accepted. All state updates for a word are shallow logic feeding one result
// register, so a word is accepted in every cycle in which the result register is
// empty or being taken: sustained rate one word per cycle. After reset the
// status reads transmit empty and the receiver waits for a start bit.
module acia_serial_interface_unit
  import acia_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,   // immediate_tx_consume
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,     // reg_select, write_data[7:0], line_level, zeros
  input  logic [2:0]            s_tuser,     // action
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata      // read_data, status_view, irq, rts, tx_bit,
                                             // tx_bit_valid, tx_bit_due, rx_clock_fire,
                                             // clock_divider[6:0], error_code[1:0],
                                             // rx_awaiting_start, rx_frame_ready, zeros
);

  // State registers
  logic       immediate_tx_consume;
  logic [7:0] control_value, status_value, status_seen;
  logic [7:0] rx_data_byte, tx_data_byte, rx_shift_byte, tx_shift_byte;
  logic       tx_data_full, parity_running, rx_parity_bad, rx_framing_bad;
  logic       overrun_pending, tx_shift_full, empty_flag_pending, cts_line, dcd_line;
  logic [3:0] rx_bit_count, tx_shift_count;
  logic [6:0] rx_tick_count;
  logic [7:0] tx_tick_count;
  rx_phase_t  rx_phase;

  logic [7:0] control_value_next, status_value_next, status_seen_next;
  logic [7:0] rx_data_byte_next, tx_data_byte_next, rx_shift_byte_next, tx_shift_byte_next;
  logic       tx_data_full_next, parity_running_next, rx_parity_bad_next;
  logic       rx_framing_bad_next, overrun_pending_next, tx_shift_full_next;
  logic       empty_flag_pending_next, cts_line_next, dcd_line_next;
  logic [3:0] rx_bit_count_next, tx_shift_count_next;
  logic [6:0] rx_tick_count_next;
  logic [7:0] tx_tick_count_next;
  rx_phase_t  rx_phase_next;

  result_t    result, result_next;
  logic       s_accept;
  action_t    action;
  logic       reg_select, line_level, master_reset;
  logic [7:0] write_data;
  logic [3:0] rx_count_inc;

  assign s_tready   = !m_tvalid || m_tready;
  assign s_accept   = s_tvalid && s_tready;
  assign action     = action_t'(s_tuser);
  assign reg_select = s_tdata[0];
  assign write_data = s_tdata[8:1];
  assign line_level = s_tdata[9];
  assign master_reset = (action == ACT_WRITE) && !reg_select &&
                        (write_data[1:0] == DIV_SEL_MRESET);
  assign rx_count_inc = rx_bit_count + 4'd1;

  // Receive framing phase
  always_comb begin
    rx_phase_next = rx_phase;
    if (action == ACT_RX_BIT) begin
      unique case (rx_phase)
        PH_START: begin
          if (!line_level) rx_phase_next = PH_DATA;
        end
        PH_DATA: begin
          if (control_value[CR_WS_8BIT]) begin
            if (rx_count_inc == 4'd8)
              rx_phase_next = control_value[CR_WS_PARITY] ? PH_PARITY : PH_STOP;
          end else if (rx_count_inc == 4'd7) begin
            rx_phase_next = PH_PARITY;
          end
        end
        PH_PARITY: rx_phase_next = PH_STOP;
        PH_STOP:   rx_phase_next = PH_START;
      endcase
    end
    if (master_reset) rx_phase_next = PH_START;
  end

  // Register, transmitter and receiver datapath for one word
  always_comb begin
    refresh_t   rf;
    logic [6:0] div;
    logic [7:0] two;
    logic [7:0] cnt;
    logic       half;
    logic [3:0] last;
    logic       kept_cts;

    control_value_next      = control_value;
    status_value_next       = status_value;
    status_seen_next        = status_seen;
    rx_data_byte_next       = rx_data_byte;
    tx_data_byte_next       = tx_data_byte;
    rx_shift_byte_next      = rx_shift_byte;
    tx_shift_byte_next      = tx_shift_byte;
    tx_data_full_next       = tx_data_full;
    parity_running_next     = parity_running;
    rx_parity_bad_next      = rx_parity_bad;
    rx_framing_bad_next     = rx_framing_bad;
    overrun_pending_next    = overrun_pending;
    tx_shift_full_next      = tx_shift_full;
    empty_flag_pending_next = empty_flag_pending;
    cts_line_next           = cts_line;
    dcd_line_next           = dcd_line;
    rx_bit_count_next       = rx_bit_count;
    tx_shift_count_next     = tx_shift_count;
    rx_tick_count_next      = rx_tick_count;
    tx_tick_count_next      = tx_tick_count;

    result_next      = '0;
    rf               = '0;
    half             = 1'b0;
    kept_cts         = status_value[ST_CTS];
    last             = control_value[CR_WS_8BIT] ? TX_LAST_8 : TX_LAST_7;
    cnt              = tx_tick_count;
    unique case (control_value[1:0])
      DIV_SEL_1:  div = DIV_1;
      DIV_SEL_16: div = DIV_16;
      default:    div = DIV_64;
    endcase
    two = {div, 1'b0};

    unique case (action)
      ACT_READ: begin
        if (!reg_select) begin
          result_next.read_data = status_seen;
        end else begin
          status_value_next[ST_DCD]  = 1'b0;
          status_value_next[ST_OVRN] = 1'b0;
          if (overrun_pending) begin
            overrun_pending_next       = 1'b0;
            status_value_next[ST_OVRN] = 1'b1;
          end else begin
            status_value_next[ST_RDRF] = 1'b0;
          end
          rf = acia_refresh(control_value_next, status_value_next, dcd_line, cts_line);
          status_value_next     = rf.st;
          status_seen_next      = rf.seen;
          result_next.read_data = rx_data_byte;
        end
      end
      ACT_WRITE: begin
        if (!reg_select) begin
          if (master_reset) begin
            // Clear all but the tx tick count, empty flag, CTS state and (CTS high) DCD line
            rx_data_byte_next   = '0;
            tx_data_byte_next   = '0;
            rx_shift_byte_next  = '0;
            rx_bit_count_next   = '0;
            parity_running_next = 1'b0;
            rx_tick_count_next  = '0;
            rx_parity_bad_next  = 1'b0;
            rx_framing_bad_next = 1'b0;
            overrun_pending_next = 1'b0;
            control_value_next  = '0;
            status_value_next   = '0;
            status_value_next[ST_TDRE] = 1'b1;
            status_value_next[ST_CTS]  = kept_cts;
            cts_line_next       = kept_cts;
            if (!kept_cts) dcd_line_next = 1'b0;
            tx_shift_count_next = '0;
            tx_shift_full_next  = 1'b0;
            tx_shift_byte_next  = '0;
            tx_data_full_next   = 1'b0;
          end else begin
            control_value_next = write_data;
          end
        end else begin
          tx_data_byte_next          = write_data;
          tx_data_full_next          = 1'b1;
          status_value_next[ST_TDRE] = 1'b0;
          if (immediate_tx_consume) begin
            tx_data_full_next          = 1'b0;
            tx_shift_full_next         = 1'b0;
            tx_shift_count_next        = '0;
            status_value_next[ST_TDRE] = 1'b1;
          end
        end
        rf = acia_refresh(control_value_next, status_value_next, dcd_line_next,
                          cts_line_next);
        status_value_next = rf.st;
        status_seen_next  = rf.seen;
      end
      ACT_RX_BIT: begin
        case (rx_phase)
          PH_START: begin
            if (!line_level && ((rx_shift_byte != 8'd0) || (rx_bit_count != 4'd0) ||
                parity_running || rx_parity_bad || rx_framing_bad))
              result_next.error_code = ERR_STATE;
          end
          PH_DATA: begin
            if (line_level) begin
              if (rx_bit_count < 4'd8) rx_shift_byte_next[rx_bit_count[2:0]] = 1'b1;
              parity_running_next = !parity_running;
            end
            rx_bit_count_next = rx_count_inc;
          end
          PH_PARITY: begin
            parity_running_next = parity_running ^ line_level;
            if (parity_running_next != control_value[CR_WS_ODD]) rx_parity_bad_next = 1'b1;
          end
          default: begin
            // Stop bit: hand the frame to the data register
            if (!line_level) rx_framing_bad_next = 1'b1;
            status_value_next[ST_RDRF] = 1'b1;
            status_value_next[ST_FE]   = 1'b0;
            status_value_next[ST_PE]   = 1'b0;
            rx_data_byte_next = rx_shift_byte;
            if (status_value[ST_RDRF]) begin
              overrun_pending_next = 1'b1;
            end else begin
              if (rx_parity_bad) status_value_next[ST_PE] = 1'b1;
              if (rx_framing_bad_next) status_value_next[ST_FE] = 1'b1;
            end
            rx_shift_byte_next  = '0;
            rx_bit_count_next   = '0;
            parity_running_next = 1'b0;
            rx_tick_count_next  = '0;
            rx_parity_bad_next  = 1'b0;
            rx_framing_bad_next = 1'b0;
            rf = acia_refresh(control_value, status_value_next, dcd_line, cts_line);
            status_value_next = rf.st;
            status_seen_next  = rf.seen;
          end
        endcase
      end
      ACT_RX_TICK: begin
        if (control_value[1:0] == DIV_SEL_MRESET) begin
          result_next.error_code = ERR_STATE;
        end else begin
          result_next.clock_divider = div;
          if (rx_tick_count >= div) begin
            result_next.rx_clock_fire = 1'b1;
            rx_tick_count_next = 7'd1;
          end else begin
            rx_tick_count_next = rx_tick_count + 7'd1;
          end
        end
      end
      ACT_TX_HALF: begin
        result_next.clock_divider = div;
        // Fold an out-of-range count back into one bit time
        if (cnt > two) begin
          cnt = cnt & (two - 8'd1);
          if (cnt == 8'd0) cnt = two;
        end
        if (cnt == two) begin
          result_next.tx_bit_due = 1'b1;
          half = 1'b1;
          cnt  = '0;
        end else if (cnt == {1'b0, div}) begin
          half = 1'b1;
        end
        if (half && empty_flag_pending) begin
          empty_flag_pending_next    = 1'b0;
          status_value_next[ST_TDRE] = 1'b1;
          rf = acia_refresh(control_value, status_value_next, dcd_line, cts_line);
          status_value_next = rf.st;
          status_seen_next  = rf.seen;
        end
        tx_tick_count_next = cnt + 8'd1;
        if (!result_next.tx_bit_due) result_next.error_code = ERR_TX_CLOCK;
      end
      ACT_TX_SHIFT: begin
        if (tx_shift_full) begin
          if (tx_shift_count > 4'd0) tx_shift_byte_next = {1'b0, tx_shift_byte[7:1]};
          if (tx_shift_count < last) begin
            tx_shift_count_next = tx_shift_count + 4'd1;
          end else if (tx_shift_count == last) begin
            tx_shift_full_next  = 1'b0;
            tx_shift_count_next = '0;
          end else begin
            result_next.error_code = ERR_STATE;
          end
          if (result_next.error_code == ERR_NONE) begin
            result_next.tx_bit       = tx_shift_byte_next[0];
            result_next.tx_bit_valid = 1'b1;
          end
        end
        // Reload the shift register from the data register
        if ((result_next.error_code == ERR_NONE) && !tx_shift_full_next && tx_data_full) begin
          tx_shift_byte_next      = tx_data_byte;
          tx_shift_full_next      = 1'b1;
          tx_shift_count_next     = '0;
          tx_data_full_next       = 1'b0;
          empty_flag_pending_next = 1'b1;
          rf = acia_refresh(control_value, status_value, dcd_line, cts_line);
          status_value_next = rf.st;
          status_seen_next  = rf.seen;
        end
      end
      ACT_DCD: begin
        if (line_level && !dcd_line) begin
          status_value_next[ST_DCD] = 1'b1;
          rf = acia_refresh(control_value, status_value_next, dcd_line, cts_line);
          status_value_next = rf.st;
          status_seen_next  = rf.seen;
        end
        dcd_line_next = line_level;
      end
      ACT_CTS: begin
        status_value_next[ST_CTS] = line_level;
        cts_line_next = line_level;
        if (!line_level) dcd_line_next = 1'b0;
        rf = acia_refresh(control_value, status_value_next, dcd_line_next, cts_line_next);
        status_value_next = rf.st;
        status_seen_next  = rf.seen;
      end
    endcase

    result_next.status_view = status_seen_next;
    result_next.irq         = status_value_next[ST_IRQ];
    result_next.rts         = !(((control_value_next & CR_TXC_MASK) == CR_TXC_RTS_OFF) ||
                                status_value_next[ST_RDRF]);
    result_next.rx_awaiting_start = (rx_phase_next == PH_START);
    result_next.rx_frame_ready    = (rx_phase_next == PH_STOP);
  end

  // Hold the configuration bit
  always_ff @(posedge clk) begin
    if (rst) immediate_tx_consume <= 1'b0;
    else if (cfg_we) immediate_tx_consume <= cfg_wdata;
  end

  // Advance the block state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      control_value      <= '0;
      status_value       <= 8'h02;
      status_seen        <= 8'h02;
      rx_data_byte       <= '0;
      tx_data_byte       <= '0;
      rx_shift_byte      <= '0;
      tx_shift_byte      <= '0;
      tx_data_full       <= 1'b0;
      parity_running     <= 1'b0;
      rx_parity_bad      <= 1'b0;
      rx_framing_bad     <= 1'b0;
      overrun_pending    <= 1'b0;
      tx_shift_full      <= 1'b0;
      empty_flag_pending <= 1'b0;
      cts_line           <= 1'b0;
      dcd_line           <= 1'b0;
      rx_bit_count       <= '0;
      tx_shift_count     <= '0;
      rx_tick_count      <= '0;
      tx_tick_count      <= '0;
      rx_phase           <= PH_START;
    end else if (s_accept) begin
      control_value      <= control_value_next;
      status_value       <= status_value_next;
      status_seen        <= status_seen_next;
      rx_data_byte       <= rx_data_byte_next;
      tx_data_byte       <= tx_data_byte_next;
      rx_shift_byte      <= rx_shift_byte_next;
      tx_shift_byte      <= tx_shift_byte_next;
      tx_data_full       <= tx_data_full_next;
      parity_running     <= parity_running_next;
      rx_parity_bad      <= rx_parity_bad_next;
      rx_framing_bad     <= rx_framing_bad_next;
      overrun_pending    <= overrun_pending_next;
      tx_shift_full      <= tx_shift_full_next;
      empty_flag_pending <= empty_flag_pending_next;
      cts_line           <= cts_line_next;
      dcd_line           <= dcd_line_next;
      rx_bit_count       <= rx_bit_count_next;
      tx_shift_count     <= tx_shift_count_next;
      rx_tick_count      <= rx_tick_count_next;
      tx_tick_count      <= tx_tick_count_next;
      rx_phase           <= rx_phase_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) result <= result_next;
  end

  assign m_tdata = result;

`ifndef SYNTHESIS
  // Master reset leaves control cleared and the receiver idle
  a_mreset: assert property (@(posedge clk) disable iff (rst)
    s_accept && master_reset |=> (control_value == 8'd0) && (rx_phase == PH_START))
    else $error("master reset did not clear control or receiver");

  // Stored control never holds the master reset code
  a_ctrl_code: assert property (@(posedge clk) disable iff (rst)
    control_value[1:0] != DIV_SEL_MRESET)
    else $error("control holds master reset code");

  // The transmit tick count stays within one bit time at the slowest divider
  a_tx_tick: assert property (@(posedge clk) disable iff (rst)
    tx_tick_count <= 8'd128)
    else $error("tx tick count out of range");

  // A produced transmit bit never comes with an error
  a_txv_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result.tx_bit_valid |-> result.error_code == ERR_NONE)
    else $error("transmit bit reported with error");
`endif

endmodule
